>>> src/dmsd_pkg.sv
// ----------------------------------------------------------------------------
// dmsd_pkg
// Shared types and constants for the dual motor / servo command driver.
// ----------------------------------------------------------------------------
package dmsd_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_ANG,
        ST_DIV180,
        ST_CLAMP,
        ST_SCALE,
        ST_DIV625,
        ST_STORE,
        ST_OUT
    } state_t;

    // command ids
    localparam logic [7:0] CMD_MOTOR1 = 8'd1;
    localparam logic [7:0] CMD_MOTOR2 = 8'd2;
    localparam logic [7:0] CMD_SERVO1 = 8'd3;
    localparam logic [7:0] CMD_SERVO2 = 8'd4;

    // motor direction codes
    localparam logic [7:0] DIR_FWD    = 8'hF0;
    localparam logic [7:0] DIR_REV    = 8'hFF;
    localparam logic [7:0] DIR_STOP_A = 8'h0F;
    localparam logic [7:0] DIR_STOP_B = 8'h00;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 2'd1;

    localparam int unsigned PULSE_W = 15;
    localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 15'd544;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 15'd2400;

    localparam logic [7:0] ANGLE_MAX = 8'd180;

    // shared multiplier operand / product widths
    localparam int unsigned MUL_A_W = 26;
    localparam int unsigned MUL_B_W = 27;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

    // x / 180 = (x * RECIP_180) >> 31, exact for x < 2**23
    localparam logic [23:0] RECIP_180 = 24'd11930465;
    localparam int unsigned Q180_LSB  = 31;

    // pulse * 65535 / 20000 = ((pulse * 65535) >> 5) / 625
    localparam logic [15:0] DUTY_FULL    = 16'hFFFF;
    localparam int unsigned PERIOD_SHIFT = 5;
    // x / 625 = (x * RECIP_625) >> 36, exact for x < 2**26
    localparam logic [26:0] RECIP_625 = 27'd109951163;
    localparam int unsigned Q625_LSB  = 36;

endpackage

>>> src/dual_motor_servo_command_driver.sv
// ----------------------------------------------------------------------------
// dual_motor_servo_command_driver
// Command packet decoder driving two H-bridges and two servo pwm duties.
// ----------------------------------------------------------------------------
// Input channel (s_*): one item per command packet (id, two argument bytes).
// Ids 1/2 update a motor speed, ids 3/4 store a servo angle, others only
// report. Result channel (m_*): one item per input item holding both bridge
// direction legs and duties and both 16-bit servo duties.
// Config port: cfg_wr_en/cfg_index/cfg_data set the min/max servo pulse
// widths; write only while the block is idle.
// Sequencing: once the item is taken, a shared 26x27 multiplier is
// sequenced through six steps per servo (angle scale, divide by 180, clamp,
// scale to duty, divide by 625, store), and then m_valid rises. s_ready is
// high only when idle, so a new item is not taken until the result has been
// accepted on the m_* channel.
// A stalled result holds on the m_* ports until taken; no new item enters.
// Reset clears speeds and angles and loads pulse limits 544 us and 2400 us.
// ----------------------------------------------------------------------------
module dual_motor_servo_command_driver (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_command,
    input  logic [7:0]  s_arg_first,
    input  logic [7:0]  s_arg_second,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_m1_forward,
    output logic        m_m1_reverse,
    output logic [7:0]  m_m1_duty,
    output logic        m_m2_forward,
    output logic        m_m2_reverse,
    output logic [7:0]  m_m2_duty,
    output logic [15:0] m_servo1_duty,
    output logic [15:0] m_servo2_duty
);

    dmsd_pkg::state_t state_reg, state_next;

    logic [14:0] min_pulse_reg, max_pulse_reg;
    logic signed [8:0] m1_speed_reg, m2_speed_reg;
    logic signed [8:0] speed_cur, speed_upd;
    logic [7:0]  s1_angle_reg, s2_angle_reg;
    logic        sel_reg;
    logic [14:0] pulse_reg;
    logic [15:0] s1_duty_reg, s2_duty_reg;
    logic [dmsd_pkg::PROD_W-1:0]  prod_reg;

    logic [dmsd_pkg::MUL_A_W-1:0] mul_a;
    logic [dmsd_pkg::MUL_B_W-1:0] mul_b;
    logic [dmsd_pkg::PROD_W-1:0]  mul_p;

    logic        accept;
    logic [7:0]  angle_sel, deg;
    logic signed [15:0] diff;
    logic        diff_neg;
    logic [14:0] diff_abs;
    logic [14:0] quot;
    logic signed [16:0] lo_s, hi_s, q_s, pulse_raw;
    logic [14:0] pulse_clamp;
    logic [16:0] duty_raw;
    logic [15:0] duty_sat;

    assign accept = s_valid && s_ready;

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dmsd_pkg::ST_IDLE:    if (s_valid) state_next = dmsd_pkg::ST_MUL_ANG;
            dmsd_pkg::ST_MUL_ANG: state_next = dmsd_pkg::ST_DIV180;
            dmsd_pkg::ST_DIV180:  state_next = dmsd_pkg::ST_CLAMP;
            dmsd_pkg::ST_CLAMP:   state_next = dmsd_pkg::ST_SCALE;
            dmsd_pkg::ST_SCALE:   state_next = dmsd_pkg::ST_DIV625;
            dmsd_pkg::ST_DIV625:  state_next = dmsd_pkg::ST_STORE;
            dmsd_pkg::ST_STORE: begin
                state_next = sel_reg ? dmsd_pkg::ST_OUT : dmsd_pkg::ST_MUL_ANG;
            end
            dmsd_pkg::ST_OUT:     if (m_ready) state_next = dmsd_pkg::ST_IDLE;
            default:              state_next = dmsd_pkg::ST_IDLE;
        endcase
    end

    // ---------------- outputs and multiplier operands ----------------
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        case (state_reg)
            dmsd_pkg::ST_IDLE: s_ready = 1'b1;
            dmsd_pkg::ST_MUL_ANG: begin
                mul_a = {11'b0, diff_abs};
                mul_b = {19'b0, deg};
            end
            dmsd_pkg::ST_DIV180: begin
                mul_a = {3'b0, prod_reg[22:0]};
                mul_b = {3'b0, dmsd_pkg::RECIP_180};
            end
            dmsd_pkg::ST_SCALE: begin
                mul_a = {11'b0, pulse_reg};
                mul_b = {11'b0, dmsd_pkg::DUTY_FULL};
            end
            dmsd_pkg::ST_DIV625: begin
                mul_a = prod_reg[dmsd_pkg::PERIOD_SHIFT +: dmsd_pkg::MUL_A_W];
                mul_b = dmsd_pkg::RECIP_625;
            end
            dmsd_pkg::ST_OUT: m_valid = 1'b1;
            default: ;
        endcase
    end

    // shared multiplier
    assign mul_p = dmsd_pkg::PROD_W'(mul_a) * dmsd_pkg::PROD_W'(mul_b);

    // ---------------- servo datapath ----------------
    assign angle_sel = sel_reg ? s2_angle_reg : s1_angle_reg;
    assign deg       = (angle_sel > dmsd_pkg::ANGLE_MAX) ? dmsd_pkg::ANGLE_MAX : angle_sel;
    assign diff      = $signed({1'b0, max_pulse_reg}) - $signed({1'b0, min_pulse_reg});
    assign diff_neg  = diff[15];
    assign diff_abs  = diff_neg ? 15'(-diff) : diff[14:0];

    assign quot      = prod_reg[dmsd_pkg::Q180_LSB +: 15];
    assign lo_s      = $signed({2'b0, min_pulse_reg});
    assign hi_s      = $signed({2'b0, max_pulse_reg});
    assign q_s       = $signed({2'b0, quot});
    // division truncates toward zero, so negate the magnitude quotient
    assign pulse_raw = diff_neg ? (lo_s - q_s) : (lo_s + q_s);

    always_comb begin
        if (pulse_raw < lo_s) begin
            pulse_clamp = min_pulse_reg;
        end else if (pulse_raw > hi_s) begin
            pulse_clamp = max_pulse_reg;
        end else begin
            pulse_clamp = pulse_raw[14:0];
        end
    end

    assign duty_raw = prod_reg[dmsd_pkg::Q625_LSB +: 17];
    assign duty_sat = duty_raw[16] ? dmsd_pkg::DUTY_FULL : duty_raw[15:0];

    // ---------------- motor speed update ----------------
    assign speed_cur = (s_command == dmsd_pkg::CMD_MOTOR2) ? m2_speed_reg : m1_speed_reg;

    always_comb begin
        case (s_arg_first)
            dmsd_pkg::DIR_FWD:    speed_upd = $signed({1'b0, s_arg_second});
            dmsd_pkg::DIR_REV:    speed_upd = 9'sd0 - $signed({1'b0, s_arg_second});
            dmsd_pkg::DIR_STOP_A,
            dmsd_pkg::DIR_STOP_B: speed_upd = 9'sd0;
            default:              speed_upd = speed_cur;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dmsd_pkg::ST_IDLE;
            min_pulse_reg <= dmsd_pkg::MIN_PULSE_RST;
            max_pulse_reg <= dmsd_pkg::MAX_PULSE_RST;
            m1_speed_reg  <= '0;
            m2_speed_reg  <= '0;
            s1_angle_reg  <= '0;
            s2_angle_reg  <= '0;
            sel_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                if (cfg_index == dmsd_pkg::REG_MIN_PULSE) min_pulse_reg <= cfg_data;
                if (cfg_index == dmsd_pkg::REG_MAX_PULSE) max_pulse_reg <= cfg_data;
            end
            if (accept) begin
                sel_reg <= 1'b0;
                case (s_command)
                    dmsd_pkg::CMD_MOTOR1: m1_speed_reg <= speed_upd;
                    dmsd_pkg::CMD_MOTOR2: m2_speed_reg <= speed_upd;
                    dmsd_pkg::CMD_SERVO1: s1_angle_reg <= s_arg_first;
                    dmsd_pkg::CMD_SERVO2: s2_angle_reg <= s_arg_first;
                    default: ;
                endcase
            end
            if (state_reg == dmsd_pkg::ST_STORE) sel_reg <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            dmsd_pkg::ST_MUL_ANG,
            dmsd_pkg::ST_DIV180,
            dmsd_pkg::ST_SCALE,
            dmsd_pkg::ST_DIV625: prod_reg <= mul_p;
            dmsd_pkg::ST_CLAMP:  pulse_reg <= pulse_clamp;
            dmsd_pkg::ST_STORE: begin
                if (sel_reg) s2_duty_reg <= duty_sat;
                else s1_duty_reg <= duty_sat;
            end
            default: ;
        endcase
    end

    // ---------------- result ports ----------------
    assign m_m1_forward  = (m1_speed_reg > 9'sd0);
    assign m_m1_reverse  = m1_speed_reg[8];
    assign m_m1_duty     = m1_speed_reg[8] ? 8'(-m1_speed_reg) : m1_speed_reg[7:0];
    assign m_m2_forward  = (m2_speed_reg > 9'sd0);
    assign m_m2_reverse  = m2_speed_reg[8];
    assign m_m2_duty     = m2_speed_reg[8] ? 8'(-m2_speed_reg) : m2_speed_reg[7:0];
    assign m_servo1_duty = s1_duty_reg;
    assign m_servo2_duty = s2_duty_reg;

endmodule

>>> sim/tb_dual_motor_servo_command_driver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_motor_servo_command_driver
// Self-checking bench for the motor / servo command driver. Command items go
// in over s_*, and each bridge and servo report coming back on m_* is
// compared field by field against an in-bench model of speeds, angles and
// pulse limits. Directed checks come first. Random traffic follows under
// three sender / receiver idling mixes and several pulse limit settings.
// ----------------------------------------------------------------------------
module tb_dual_motor_servo_command_driver;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          PERIOD_US   = 20000;
    localparam int unsigned ITEMS_PER_CHUNK = 46;
    localparam int unsigned END_SETTLE = 20;
    localparam logic [dmsd_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [dmsd_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic        m1_forward;
        logic        m1_reverse;
        logic [7:0]  m1_duty;
        logic        m2_forward;
        logic        m2_reverse;
        logic [7:0]  m2_duty;
        logic [15:0] servo1_duty;
        logic [15:0] servo2_duty;
    } bridge_report_t;

    logic                         aclk;
    logic                         aresetn = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic [1:0]                   cfg_index = '0;
    logic [dmsd_pkg::PULSE_W-1:0] cfg_data = '0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [7:0]                   s_command = '0;
    logic [7:0]                   s_arg_first = '0;
    logic [7:0]                   s_arg_second = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic                         m_m1_forward;
    logic                         m_m1_reverse;
    logic [7:0]                   m_m1_duty;
    logic                         m_m2_forward;
    logic                         m_m2_reverse;
    logic [7:0]                   m_m2_duty;
    logic [15:0]                  m_servo1_duty;
    logic [15:0]                  m_servo2_duty;

    // model state
    logic signed [8:0]            speed_m1 = '0;
    logic signed [8:0]            speed_m2 = '0;
    logic [7:0]                   angle_s1 = '0;
    logic [7:0]                   angle_s2 = '0;
    logic [dmsd_pkg::PULSE_W-1:0] lim_min = dmsd_pkg::MIN_PULSE_RST;
    logic [dmsd_pkg::PULSE_W-1:0] lim_max = dmsd_pkg::MAX_PULSE_RST;

    bridge_report_t expected_reports[$];
    int unsigned    mismatch_count = 0;
    int unsigned    cycle_count = 0;
    int unsigned    tx_idle_pct = 0;
    int unsigned    rx_idle_pct = 0;

    dual_motor_servo_command_driver DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_arg_first   (s_arg_first),
        .s_arg_second  (s_arg_second),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_m1_forward  (m_m1_forward),
        .m_m1_reverse  (m_m1_reverse),
        .m_m1_duty     (m_m1_duty),
        .m_m2_forward  (m_m2_forward),
        .m_m2_reverse  (m_m2_reverse),
        .m_m2_duty     (m_m2_duty),
        .m_servo1_duty (m_servo1_duty),
        .m_servo2_duty (m_servo2_duty)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------
    function automatic logic signed [8:0] next_speed(input logic signed [8:0] cur,
                                                     input logic [7:0] code,
                                                     input logic [7:0] mag);
        case (code)
            dmsd_pkg::DIR_FWD:    return $signed({1'b0, mag});
            dmsd_pkg::DIR_REV:    return -$signed({1'b0, mag});
            dmsd_pkg::DIR_STOP_A,
            dmsd_pkg::DIR_STOP_B: return '0;
            default:              return cur;
        endcase
    endfunction

    function automatic logic [15:0] servo_duty_of(input logic [7:0] angle);
        int     lo;
        int     hi;
        int     deg;
        int     pulse;
        longint duty;
        lo  = int'(lim_min);
        hi  = int'(lim_max);
        deg = (angle > dmsd_pkg::ANGLE_MAX) ? int'(dmsd_pkg::ANGLE_MAX) : int'(angle);
        // int division truncates toward zero, which reversed limits rely on
        pulse = (deg * (hi - lo)) / int'(dmsd_pkg::ANGLE_MAX) + lo;
        if (pulse < lo) begin
            pulse = lo;
        end else if (pulse > hi) begin
            pulse = hi;
        end
        if (pulse < 0) begin
            pulse = 0;
        end
        duty = (longint'(pulse) * longint'(dmsd_pkg::DUTY_FULL)) / PERIOD_US;
        if (duty > longint'(dmsd_pkg::DUTY_FULL)) begin
            duty = longint'(dmsd_pkg::DUTY_FULL);
        end
        return duty[15:0];
    endfunction

    function automatic void bridge_of(input logic signed [8:0] speed, output logic fwd,
                                      output logic rev, output logic [7:0] duty);
        logic signed [8:0] mag;
        fwd  = (speed > 0);
        rev  = (speed < 0);
        mag  = (speed < 0) ? -speed : speed;
        duty = mag[7:0];
    endfunction

    task automatic apply_command(input logic [7:0] cmd, input logic [7:0] a1,
                                 input logic [7:0] a2);
        bridge_report_t rep;
        case (cmd)
            dmsd_pkg::CMD_MOTOR1: speed_m1 = next_speed(speed_m1, a1, a2);
            dmsd_pkg::CMD_MOTOR2: speed_m2 = next_speed(speed_m2, a1, a2);
            dmsd_pkg::CMD_SERVO1: angle_s1 = a1;
            dmsd_pkg::CMD_SERVO2: angle_s2 = a1;
            default: ;
        endcase
        bridge_of(speed_m1, rep.m1_forward, rep.m1_reverse, rep.m1_duty);
        bridge_of(speed_m2, rep.m2_forward, rep.m2_reverse, rep.m2_duty);
        rep.servo1_duty = servo_duty_of(angle_s1);
        rep.servo2_duty = servo_duty_of(angle_s2);
        expected_reports.push_back(rep);
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    function automatic string report_text(input bridge_report_t r);
        return $sformatf("m1 f%0d r%0d d%0d  m2 f%0d r%0d d%0d  s1 %0d  s2 %0d",
                         r.m1_forward, r.m1_reverse, r.m1_duty, r.m2_forward,
                         r.m2_reverse, r.m2_duty, r.servo1_duty, r.servo2_duty);
    endfunction

    always @(posedge aclk) begin
        bridge_report_t got;
        bridge_report_t want;
        logic           bad;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_m1_forward, m_m1_reverse, m_m1_duty, m_m2_forward, m_m2_reverse,
                    m_m2_duty, m_servo1_duty, m_servo2_duty};
            if (expected_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("[%0t] unexpected item: %s", $realtime, report_text(got));
                end
            end else begin
                want = expected_reports.pop_front();
                bad = (got.m1_forward !== want.m1_forward) ||
                      (got.m1_reverse !== want.m1_reverse) ||
                      (got.m1_duty !== want.m1_duty) ||
                      (got.m2_forward !== want.m2_forward) ||
                      (got.m2_reverse !== want.m2_reverse) ||
                      (got.m2_duty !== want.m2_duty) ||
                      (got.servo1_duty !== want.servo1_duty) ||
                      (got.servo2_duty !== want.servo2_duty);
                if (bad) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("[%0t] mismatch", $realtime);
                        $display("    expected: %s", report_text(want));
                        $display("    actual:   %s", report_text(got));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_item(input logic [7:0] cmd, input logic [7:0] a1,
                             input logic [7:0] a2);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_arg_first  <= a1;
        s_arg_second <= a2;
        do @(posedge aclk); while (!(s_valid && s_ready));
        apply_command(cmd, a1, a2);
    endtask

    // sender holds off until every pending result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_reports.size() != 0);
    endtask

    // enable stays high across back-to-back writes, dropped once at the end
    task automatic write_reg(input logic [1:0] idx,
                             input logic [dmsd_pkg::PULSE_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        if (idx == dmsd_pkg::REG_MIN_PULSE) begin
            lim_min = data;
        end else if (idx == dmsd_pkg::REG_MAX_PULSE) begin
            lim_max = data;
        end
    endtask

    task automatic configure(input logic [dmsd_pkg::PULSE_W-1:0] lo,
                             input logic [dmsd_pkg::PULSE_W-1:0] hi);
        wait_drained();
        write_reg(dmsd_pkg::REG_MIN_PULSE, lo);
        write_reg(dmsd_pkg::REG_MAX_PULSE, hi);
        // spare indexes must not touch the limits
        write_reg(REG_SPARE_2, dmsd_pkg::PULSE_W'($urandom_range(32767)));
        write_reg(REG_SPARE_3, dmsd_pkg::PULSE_W'($urandom_range(32767)));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_state();
        send_item(8'h00, 8'h00, 8'h00);
        send_item(8'hFF, 8'hFF, 8'hFF);
    endtask

    task automatic test_motor_codes();
        send_item(dmsd_pkg::CMD_MOTOR1, dmsd_pkg::DIR_FWD, 8'd255);
        send_item(dmsd_pkg::CMD_MOTOR1, 8'h5A, 8'd17);      // unknown code keeps speed
        send_item(dmsd_pkg::CMD_MOTOR1, dmsd_pkg::DIR_REV, 8'd255);
        send_item(dmsd_pkg::CMD_MOTOR1, dmsd_pkg::DIR_STOP_A, 8'd99);
        send_item(dmsd_pkg::CMD_MOTOR2, dmsd_pkg::DIR_FWD, 8'd1);
        send_item(dmsd_pkg::CMD_MOTOR2, dmsd_pkg::DIR_REV, 8'd128);
        send_item(dmsd_pkg::CMD_MOTOR2, 8'hFE, 8'd3);
        send_item(dmsd_pkg::CMD_MOTOR2, dmsd_pkg::DIR_STOP_B, 8'd200);
        send_item(dmsd_pkg::CMD_MOTOR1, dmsd_pkg::DIR_REV, 8'd0);
    endtask

    task automatic test_servo_angles();
        send_item(dmsd_pkg::CMD_SERVO1, 8'd0, 8'hFF);
        send_item(dmsd_pkg::CMD_SERVO1, 8'd180, 8'h00);
        send_item(dmsd_pkg::CMD_SERVO1, 8'd255, 8'h5A);     // above 180 clamps on use
        send_item(dmsd_pkg::CMD_SERVO2, 8'd90, 8'h00);
        send_item(dmsd_pkg::CMD_SERVO2, 8'd181, 8'h00);
        send_item(dmsd_pkg::CMD_SERVO2, 8'd179, 8'h00);
        send_item(dmsd_pkg::CMD_SERVO1, 8'd1, 8'h00);
    endtask

    task automatic test_pulse_limits();
        configure(15'd2400, 15'd544);             // reversed limits
        send_item(dmsd_pkg::CMD_SERVO1, 8'd90, 8'h00);
        send_item(dmsd_pkg::CMD_SERVO2, 8'd0, 8'h00);
        send_item(dmsd_pkg::CMD_SERVO1, 8'd180, 8'h00);
        configure(15'd0, 15'd32767);              // pulse beyond the period
        send_item(dmsd_pkg::CMD_SERVO1, 8'd180, 8'h00);
        send_item(dmsd_pkg::CMD_SERVO2, 8'd200, 8'h00);
        configure(15'd32767, 15'd0);
        send_item(dmsd_pkg::CMD_SERVO1, 8'd45, 8'h00);
        configure(15'd0, 15'd0);
        send_item(dmsd_pkg::CMD_SERVO2, 8'd90, 8'h00);
    endtask

    task automatic send_random_command();
        logic [7:0] cmd;
        logic [7:0] a1;
        logic [7:0] a2;
        a2 = 8'($urandom_range(255));
        if ($urandom_range(99) < 15) begin
            cmd = 8'($urandom_range(255));
            a1  = 8'($urandom_range(255));
        end else begin
            case ($urandom_range(3))
                0:       cmd = dmsd_pkg::CMD_MOTOR1;
                1:       cmd = dmsd_pkg::CMD_MOTOR2;
                2:       cmd = dmsd_pkg::CMD_SERVO1;
                default: cmd = dmsd_pkg::CMD_SERVO2;
            endcase
            if (cmd == dmsd_pkg::CMD_MOTOR1 || cmd == dmsd_pkg::CMD_MOTOR2) begin
                case ($urandom_range(4))
                    0:       a1 = dmsd_pkg::DIR_FWD;
                    1:       a1 = dmsd_pkg::DIR_REV;
                    2:       a1 = dmsd_pkg::DIR_STOP_A;
                    3:       a1 = dmsd_pkg::DIR_STOP_B;
                    default: a1 = 8'($urandom_range(255));
                endcase
            end else begin
                a1 = ($urandom_range(99) < 80) ? 8'($urandom_range(180))
                                               : 8'($urandom_range(255));
            end
        end
        send_item(cmd, a1, a2);
    endtask

    task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct);
        logic [dmsd_pkg::PULSE_W-1:0] lo;
        logic [dmsd_pkg::PULSE_W-1:0] hi;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int chunk = 0; chunk < 4; chunk++) begin
            case (chunk)
                0: begin
                    lo = dmsd_pkg::MIN_PULSE_RST;
                    hi = dmsd_pkg::MAX_PULSE_RST;
                end
                1: begin
                    lo = dmsd_pkg::PULSE_W'($urandom_range(3000));
                    hi = dmsd_pkg::PULSE_W'($urandom_range(20000, lo));
                end
                2: begin
                    hi = dmsd_pkg::PULSE_W'($urandom_range(3000));
                    lo = dmsd_pkg::PULSE_W'($urandom_range(20000, hi));
                end
                default: begin
                    lo = dmsd_pkg::PULSE_W'($urandom_range(32767));
                    hi = dmsd_pkg::PULSE_W'($urandom_range(32767));
                end
            endcase
            configure(lo, hi);
            for (int n = 0; n < ITEMS_PER_CHUNK; n++) begin
                if ($urandom_range(99) < 2) begin
                    wait_drained();
                end
                send_random_command();
            end
        end
    endtask

    initial begin
        tx_idle_pct = 28;
        rx_idle_pct = 57;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_motor_codes();
        test_servo_angles();
        test_pulse_limits();
        test_random_traffic(28, 57);
        test_random_traffic(57, 28);
        test_random_traffic(0, 0);

        wait_drained();
        repeat (END_SETTLE) @(posedge aclk);
        if (mismatch_count == 0 && expected_reports.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> dual_motor_servo_command_driver.f
src/dmsd_pkg.sv
src/dual_motor_servo_command_driver.sv
sim/tb_dual_motor_servo_command_driver.sv
